>>> rtl/m4au_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4au_pkg
// Types, constants and fixed-point helpers shared by the 4x4 matrix unit.
// ----------------------------------------------------------------------------
package m4au_pkg;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int SW = 36;
    localparam int QW = VW + FB;

    localparam logic signed [VW-1:0] MAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] MINV = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0]        ONE  = VW'(1) << FB;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [2:0] SCR_M01 = 3'd0;
    localparam logic [2:0] SCR_M02 = 3'd1;
    localparam logic [2:0] SCR_M03 = 3'd2;
    localparam logic [2:0] SCR_M12 = 3'd3;
    localparam logic [2:0] SCR_M13 = 3'd4;
    localparam logic [2:0] SCR_M23 = 3'd5;
    localparam logic [2:0] SCR_C3  = 3'd6;

    localparam logic [4:0] DET_LAST = 5'd27;
    localparam logic [5:0] DIV_LAST = 6'(QW - 1);

    typedef enum logic [3:0] {
        ACT_WR_OP  = 4'd0,
        ACT_WR_ACC = 4'd1,
        ACT_ADD    = 4'd2,
        ACT_SUB    = 4'd3,
        ACT_MATMUL = 4'd4,
        ACT_SCALE  = 4'd5,
        ACT_DIVIDE = 4'd6,
        ACT_TRANSP = 4'd7,
        ACT_READ   = 4'd8,
        ACT_DET    = 4'd9,
        ACT_IDENT  = 4'd10
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ELEM, S_COPY, S_MLOAD, S_MUL, S_MACC, S_SLOAD, S_SWR,
        S_DINIT, S_DSTEP, S_DWR, S_XLDX, S_XLDY, S_XACC, S_XFIN, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_WR_OP, DP_WR_ACC, DP_READ, DP_ADDSUB, DP_IDENT, DP_TR, DP_COPY,
        DP_LD_AO, DP_LD_AV, DP_LD_XO, DP_LD_Y, DP_MUL, DP_SUMP, DP_DETP,
        DP_DET_FIN, DP_WR_FM, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_WR, DP_DIVZ
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [3:0] addr_a;
        logic [3:0] addr_b;
        logic       b_scr;
        logic       first;
        logic       neg;
        logic       sub;
        logic       store_tmp;
        logic       store_scr;
        logic [2:0] dst;
        logic       accept;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic val_zero;
    } t_dp_status;

    typedef struct packed {
        logic                 sat;
        logic signed [VW-1:0] v;
    } t_sat_val;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic       b_scr;
        logic       neg;
        logic       first;
        logic       store;
        logic [2:0] dst;
        logic       to_det;
    } t_det_uop;

    // Saturate a wide exact sum to the element range.
    function automatic t_sat_val sat_wide(input logic signed [SW-1:0] x);
        t_sat_val r;
        if (x > SW'(MAXV)) begin
            r.sat = 1'b1;
            r.v   = MAXV;
        end else if (x < SW'(MINV)) begin
            r.sat = 1'b1;
            r.v   = MINV;
        end else begin
            r.sat = 1'b0;
            r.v   = x[VW-1:0];
        end
        return r;
    endfunction

    // Fixed-point product: floor of the full product over 2^FB, saturated.
    function automatic t_sat_val fmul_sat(input logic signed [2*VW-1:0] p);
        t_sat_val             r;
        logic signed [QW-1:0] sh;
        sh = p[2*VW-1:FB];
        if (sh > QW'(MAXV)) begin
            r.sat = 1'b1;
            r.v   = MAXV;
        end else if (sh < QW'(MINV)) begin
            r.sat = 1'b1;
            r.v   = MINV;
        end else begin
            r.sat = 1'b0;
            r.v   = sh[VW-1:0];
        end
        return r;
    endfunction

    // Signed quotient from its magnitude, saturated.
    function automatic t_sat_val div_fix(input logic neg, input logic [QW-1:0] q);
        t_sat_val      r;
        logic [QW-1:0] nq;
        nq = ~q + QW'(1);
        r.sat = 1'b0;
        if (!neg) begin
            if (q > QW'(MAXV)) begin
                r.sat = 1'b1;
                r.v   = MAXV;
            end else begin
                r.v = q[VW-1:0];
            end
        end else begin
            if (q > (QW'(MAXV) + QW'(1))) begin
                r.sat = 1'b1;
                r.v   = MINV;
            end else begin
                r.v = nq[VW-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] x);
        return x[VW-1] ? (~x + VW'(1)) : x;
    endfunction

    function automatic t_det_uop mk(input logic [3:0] a, input logic [3:0] b,
                                    input logic b_scr, input logic neg,
                                    input logic first, input logic store,
                                    input logic [2:0] dst, input logic to_det);
        t_det_uop u;
        u.a = a; u.b = b; u.b_scr = b_scr; u.neg = neg; u.first = first;
        u.store = store; u.dst = dst; u.to_det = to_det;
        return u;
    endfunction

    // Determinant sequence: six 2x2 minors of rows 2 and 3, then for each
    // column of row 0 a 3x3 cofactor over row 1 and its signed term.
    function automatic t_det_uop det_uop(input logic [4:0] i);
        t_det_uop u;
        case (i)
            5'd0:  u = mk(4'd8,  4'd13, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M01, 1'b0);
            5'd1:  u = mk(4'd9,  4'd12, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M01, 1'b0);
            5'd2:  u = mk(4'd8,  4'd14, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M02, 1'b0);
            5'd3:  u = mk(4'd10, 4'd12, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M02, 1'b0);
            5'd4:  u = mk(4'd8,  4'd15, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M03, 1'b0);
            5'd5:  u = mk(4'd11, 4'd12, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M03, 1'b0);
            5'd6:  u = mk(4'd9,  4'd14, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M12, 1'b0);
            5'd7:  u = mk(4'd10, 4'd13, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M12, 1'b0);
            5'd8:  u = mk(4'd9,  4'd15, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M13, 1'b0);
            5'd9:  u = mk(4'd11, 4'd13, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M13, 1'b0);
            5'd10: u = mk(4'd10, 4'd15, 1'b0, 1'b0, 1'b1, 1'b0, SCR_M23, 1'b0);
            5'd11: u = mk(4'd11, 4'd14, 1'b0, 1'b1, 1'b0, 1'b1, SCR_M23, 1'b0);
            5'd12: u = mk(4'd5, {1'b0, SCR_M23}, 1'b1, 1'b0, 1'b1, 1'b0, SCR_C3, 1'b0);
            5'd13: u = mk(4'd6, {1'b0, SCR_M13}, 1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b0);
            5'd14: u = mk(4'd7, {1'b0, SCR_M12}, 1'b1, 1'b0, 1'b0, 1'b1, SCR_C3, 1'b0);
            5'd15: u = mk(4'd0, {1'b0, SCR_C3},  1'b1, 1'b0, 1'b1, 1'b0, SCR_C3, 1'b1);
            5'd16: u = mk(4'd4, {1'b0, SCR_M23}, 1'b1, 1'b0, 1'b1, 1'b0, SCR_C3, 1'b0);
            5'd17: u = mk(4'd6, {1'b0, SCR_M03}, 1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b0);
            5'd18: u = mk(4'd7, {1'b0, SCR_M02}, 1'b1, 1'b0, 1'b0, 1'b1, SCR_C3, 1'b0);
            5'd19: u = mk(4'd1, {1'b0, SCR_C3},  1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b1);
            5'd20: u = mk(4'd4, {1'b0, SCR_M13}, 1'b1, 1'b0, 1'b1, 1'b0, SCR_C3, 1'b0);
            5'd21: u = mk(4'd5, {1'b0, SCR_M03}, 1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b0);
            5'd22: u = mk(4'd7, {1'b0, SCR_M01}, 1'b1, 1'b0, 1'b0, 1'b1, SCR_C3, 1'b0);
            5'd23: u = mk(4'd2, {1'b0, SCR_C3},  1'b1, 1'b0, 1'b0, 1'b0, SCR_C3, 1'b1);
            5'd24: u = mk(4'd4, {1'b0, SCR_M12}, 1'b1, 1'b0, 1'b1, 1'b0, SCR_C3, 1'b0);
            5'd25: u = mk(4'd5, {1'b0, SCR_M02}, 1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b0);
            5'd26: u = mk(4'd6, {1'b0, SCR_M01}, 1'b1, 1'b0, 1'b0, 1'b1, SCR_C3, 1'b0);
            5'd27: u = mk(4'd3, {1'b0, SCR_C3},  1'b1, 1'b1, 1'b0, 1'b0, SCR_C3, 1'b1);
            default: u = mk(4'd0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, SCR_C3, 1'b0);
        endcase
        return u;
    endfunction

endpackage

>>> rtl/m4au_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4au_ctrl
// Sequencer: walks elements, multiply steps, divider bits and the
// determinant sequence, and issues one datapath command each cycle.
// ----------------------------------------------------------------------------
module m4au_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [3:0]           i_action,
    input  m4au_pkg::t_dp_status i_status,
    output m4au_pkg::t_dp_cmd    o_cmd,
    output logic                 busy
);

    m4au_pkg::t_state  r_state, n_state;
    m4au_pkg::t_action r_action, n_action;
    logic [3:0] r_e, n_e;
    logic [1:0] r_k, n_k;
    logic [5:0] r_cnt, n_cnt;
    logic [4:0] r_u, n_u;
    m4au_pkg::t_det_uop uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= m4au_pkg::S_IDLE;
            r_action <= m4au_pkg::ACT_WR_OP;
            r_e      <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_u      <= '0;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
            r_e      <= n_e;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_u      <= n_u;
        end
    end

    always_comb begin
        uop      = m4au_pkg::det_uop(r_u);
        n_state  = r_state;
        n_action = r_action;
        n_e      = r_e;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_u      = r_u;
        o_cmd    = '0;
        o_cmd.op = m4au_pkg::DP_NOP;
        busy     = (r_state != m4au_pkg::S_IDLE);
        case (r_state)
            m4au_pkg::S_IDLE: begin
                o_cmd.accept = start;
                if (start) begin
                    n_action = m4au_pkg::t_action'(i_action);
                    n_state  = m4au_pkg::S_DISP;
                    n_e      = '0;
                    n_k      = '0;
                    n_u      = '0;
                end
            end
            m4au_pkg::S_DISP: begin
                n_state = m4au_pkg::S_DONE;
                case (r_action)
                    m4au_pkg::ACT_WR_OP:  o_cmd.op = m4au_pkg::DP_WR_OP;
                    m4au_pkg::ACT_WR_ACC: o_cmd.op = m4au_pkg::DP_WR_ACC;
                    m4au_pkg::ACT_READ:   o_cmd.op = m4au_pkg::DP_READ;
                    m4au_pkg::ACT_ADD, m4au_pkg::ACT_SUB, m4au_pkg::ACT_IDENT,
                    m4au_pkg::ACT_TRANSP: n_state = m4au_pkg::S_ELEM;
                    m4au_pkg::ACT_MATMUL: n_state = m4au_pkg::S_MLOAD;
                    m4au_pkg::ACT_SCALE:  n_state = m4au_pkg::S_SLOAD;
                    m4au_pkg::ACT_DET:    n_state = m4au_pkg::S_XLDX;
                    m4au_pkg::ACT_DIVIDE: begin
                        if (i_status.val_zero) begin
                            o_cmd.op = m4au_pkg::DP_DIVZ;
                        end else begin
                            n_state = m4au_pkg::S_DINIT;
                        end
                    end
                    default: n_state = m4au_pkg::S_DONE;
                endcase
            end
            m4au_pkg::S_ELEM: begin
                o_cmd.addr_a = r_e;
                o_cmd.addr_b = {r_e[1:0], r_e[3:2]};
                o_cmd.sub    = (r_action == m4au_pkg::ACT_SUB);
                case (r_action)
                    m4au_pkg::ACT_IDENT:  o_cmd.op = m4au_pkg::DP_IDENT;
                    m4au_pkg::ACT_TRANSP: o_cmd.op = m4au_pkg::DP_TR;
                    default:              o_cmd.op = m4au_pkg::DP_ADDSUB;
                endcase
                n_e = r_e + 4'd1;
                if (r_e == 4'd15) begin
                    n_state = (r_action == m4au_pkg::ACT_TRANSP) ? m4au_pkg::S_COPY
                                                                 : m4au_pkg::S_DONE;
                end
            end
            m4au_pkg::S_COPY: begin
                o_cmd.op     = m4au_pkg::DP_COPY;
                o_cmd.addr_a = r_e;
                n_e          = r_e + 4'd1;
                if (r_e == 4'd15) begin
                    n_state = m4au_pkg::S_DONE;
                end
            end
            m4au_pkg::S_MLOAD: begin
                o_cmd.op     = m4au_pkg::DP_LD_AO;
                o_cmd.addr_a = {r_e[3:2], r_k};
                o_cmd.addr_b = {r_k, r_e[1:0]};
                n_state      = m4au_pkg::S_MUL;
            end
            m4au_pkg::S_MUL: begin
                o_cmd.op = m4au_pkg::DP_MUL;
                case (r_action)
                    m4au_pkg::ACT_MATMUL: n_state = m4au_pkg::S_MACC;
                    m4au_pkg::ACT_SCALE:  n_state = m4au_pkg::S_SWR;
                    default:              n_state = m4au_pkg::S_XACC;
                endcase
            end
            m4au_pkg::S_MACC: begin
                o_cmd.op        = m4au_pkg::DP_SUMP;
                o_cmd.addr_a    = r_e;
                o_cmd.first     = (r_k == 2'd0);
                o_cmd.store_tmp = (r_k == 2'd3);
                n_k             = r_k + 2'd1;
                n_state         = m4au_pkg::S_MLOAD;
                if (r_k == 2'd3) begin
                    n_e = r_e + 4'd1;
                    if (r_e == 4'd15) begin
                        n_state = m4au_pkg::S_COPY;
                    end
                end
            end
            m4au_pkg::S_SLOAD: begin
                o_cmd.op     = m4au_pkg::DP_LD_AV;
                o_cmd.addr_a = r_e;
                n_state      = m4au_pkg::S_MUL;
            end
            m4au_pkg::S_SWR: begin
                o_cmd.op     = m4au_pkg::DP_WR_FM;
                o_cmd.addr_a = r_e;
                n_e          = r_e + 4'd1;
                n_state      = (r_e == 4'd15) ? m4au_pkg::S_DONE : m4au_pkg::S_SLOAD;
            end
            m4au_pkg::S_DINIT: begin
                o_cmd.op     = m4au_pkg::DP_DIV_INIT;
                o_cmd.addr_a = r_e;
                n_cnt        = '0;
                n_state      = m4au_pkg::S_DSTEP;
            end
            m4au_pkg::S_DSTEP: begin
                o_cmd.op = m4au_pkg::DP_DIV_STEP;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == m4au_pkg::DIV_LAST) begin
                    n_state = m4au_pkg::S_DWR;
                end
            end
            m4au_pkg::S_DWR: begin
                o_cmd.op     = m4au_pkg::DP_DIV_WR;
                o_cmd.addr_a = r_e;
                n_e          = r_e + 4'd1;
                n_state      = (r_e == 4'd15) ? m4au_pkg::S_DONE : m4au_pkg::S_DINIT;
            end
            m4au_pkg::S_XLDX: begin
                o_cmd.op     = m4au_pkg::DP_LD_XO;
                o_cmd.addr_a = uop.a;
                n_state      = m4au_pkg::S_XLDY;
            end
            m4au_pkg::S_XLDY: begin
                o_cmd.op     = m4au_pkg::DP_LD_Y;
                o_cmd.addr_b = uop.b;
                o_cmd.b_scr  = uop.b_scr;
                n_state      = m4au_pkg::S_MUL;
            end
            m4au_pkg::S_XACC: begin
                o_cmd.op        = uop.to_det ? m4au_pkg::DP_DETP : m4au_pkg::DP_SUMP;
                o_cmd.first     = uop.first;
                o_cmd.neg       = uop.neg;
                o_cmd.store_scr = uop.store & ~uop.to_det;
                o_cmd.dst       = uop.dst;
                n_u             = r_u + 5'd1;
                n_state = (r_u == m4au_pkg::DET_LAST) ? m4au_pkg::S_XFIN : m4au_pkg::S_XLDX;
            end
            m4au_pkg::S_XFIN: begin
                o_cmd.op = m4au_pkg::DP_DET_FIN;
                n_state  = m4au_pkg::S_DONE;
            end
            m4au_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = m4au_pkg::S_IDLE;
            end
            default: n_state = m4au_pkg::S_IDLE;
        endcase
    end

endmodule

>>> rtl/m4au_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4au_datapath
// Matrix storage, one shared multiplier, sum registers, a radix-2 divider
// and the result register.
// ----------------------------------------------------------------------------
module m4au_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  m4au_pkg::t_dp_cmd           i_cmd,
    input  logic [1:0]                  i_row,
    input  logic [1:0]                  i_col,
    input  logic signed [31:0]          i_value,
    output m4au_pkg::t_dp_status        o_status_dp,
    output logic                        o_strobe,
    output logic signed [31:0]          o_result_value,
    output logic [1:0]                  o_status
);

    logic signed [31:0] r_acc [16];
    logic signed [31:0] r_op  [16];
    logic signed [31:0] r_tmp [16];
    logic signed [31:0] r_scr [8];

    logic signed [31:0] r_val, r_x, r_y, r_res;
    logic [3:0]         r_idx;
    logic signed [63:0] r_prod;
    logic signed [35:0] r_sum, r_det;
    logic               r_sat, r_divz, r_strobe;
    logic [47:0]        r_num, r_q;
    logic [31:0]        r_rem, r_dmag;
    logic               r_dneg;

    logic [3:0]         acc_ra, op_ra;
    logic signed [31:0] acc_rd, op_rd, scr_rd, tmp_rd, a_mag;
    m4au_pkg::t_sat_val fm, as, sum_s, det_s, dq;
    logic signed [35:0] sum_b, sum_n, det_b, det_n, as_n, fm_w;
    logic [32:0]        div_t;
    logic               div_ge;
    logic               sat_set;

    always_comb begin
        acc_ra = i_cmd.addr_a;
        if (i_cmd.op == m4au_pkg::DP_TR) begin
            acc_ra = i_cmd.addr_b;
        end else if (i_cmd.op == m4au_pkg::DP_READ) begin
            acc_ra = r_idx;
        end
        op_ra = (i_cmd.op == m4au_pkg::DP_LD_AO || i_cmd.op == m4au_pkg::DP_LD_Y)
              ? i_cmd.addr_b : i_cmd.addr_a;
        acc_rd = r_acc[acc_ra];
        op_rd  = r_op[op_ra];
        scr_rd = r_scr[i_cmd.addr_b[2:0]];
        tmp_rd = r_tmp[i_cmd.addr_a];
        a_mag  = m4au_pkg::mag(acc_rd);

        fm    = m4au_pkg::fmul_sat(r_prod);
        fm_w  = 36'(fm.v);
        sum_b = i_cmd.first ? '0 : r_sum;
        sum_n = i_cmd.neg ? (sum_b - fm_w) : (sum_b + fm_w);
        sum_s = m4au_pkg::sat_wide(sum_n);
        det_b = i_cmd.first ? '0 : r_det;
        det_n = i_cmd.neg ? (det_b - fm_w) : (det_b + fm_w);
        det_s = m4au_pkg::sat_wide(r_det);
        as_n  = i_cmd.sub ? (36'(acc_rd) - 36'(op_rd)) : (36'(acc_rd) + 36'(op_rd));
        as    = m4au_pkg::sat_wide(as_n);
        dq    = m4au_pkg::div_fix(r_dneg, r_q);

        div_t  = {r_rem, r_num[47]};
        div_ge = (div_t >= {1'b0, r_dmag});

        case (i_cmd.op)
            m4au_pkg::DP_ADDSUB:  sat_set = as.sat;
            m4au_pkg::DP_WR_FM,
            m4au_pkg::DP_DETP:    sat_set = fm.sat;
            m4au_pkg::DP_SUMP:    sat_set = fm.sat |
                                  ((i_cmd.store_tmp | i_cmd.store_scr) & sum_s.sat);
            m4au_pkg::DP_DET_FIN: sat_set = det_s.sat;
            m4au_pkg::DP_DIV_WR:  sat_set = dq.sat;
            default:              sat_set = 1'b0;
        endcase
        o_status_dp.val_zero = (r_val == '0);
    end

    // Matrix state and control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_acc[i] <= '0;
                r_op[i]  <= '0;
            end
            r_sat    <= 1'b0;
            r_divz   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.accept) begin
                r_sat  <= 1'b0;
                r_divz <= 1'b0;
            end else if (sat_set) begin
                r_sat <= 1'b1;
            end
            case (i_cmd.op)
                m4au_pkg::DP_WR_OP:  r_op[r_idx]  <= r_val;
                m4au_pkg::DP_WR_ACC: r_acc[r_idx] <= r_val;
                m4au_pkg::DP_ADDSUB: r_acc[i_cmd.addr_a] <= as.v;
                m4au_pkg::DP_IDENT:  r_acc[i_cmd.addr_a] <=
                    (i_cmd.addr_a[3:2] == i_cmd.addr_a[1:0]) ? m4au_pkg::ONE : '0;
                m4au_pkg::DP_COPY:   r_acc[i_cmd.addr_a] <= tmp_rd;
                m4au_pkg::DP_WR_FM:  r_acc[i_cmd.addr_a] <= fm.v;
                m4au_pkg::DP_DIV_WR: r_acc[i_cmd.addr_a] <= dq.v;
                m4au_pkg::DP_DIVZ:   r_divz <= 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val <= i_value;
            r_idx <= {i_row, i_col};
            r_res <= '0;
        end
        if (i_cmd.finish) begin
            o_result_value <= r_res;
            o_status <= r_divz ? m4au_pkg::ST_DIVZ
                      : (r_sat ? m4au_pkg::ST_SAT : m4au_pkg::ST_OK);
        end
        case (i_cmd.op)
            m4au_pkg::DP_READ:  r_res <= acc_rd;
            m4au_pkg::DP_TR:    r_tmp[i_cmd.addr_a] <= acc_rd;
            m4au_pkg::DP_LD_AO: begin
                r_x <= acc_rd;
                r_y <= op_rd;
            end
            m4au_pkg::DP_LD_AV: begin
                r_x <= acc_rd;
                r_y <= r_val;
            end
            m4au_pkg::DP_LD_XO: r_x <= op_rd;
            m4au_pkg::DP_LD_Y:  r_y <= i_cmd.b_scr ? scr_rd : op_rd;
            m4au_pkg::DP_MUL:   r_prod <= r_x * r_y;
            m4au_pkg::DP_SUMP: begin
                r_sum <= sum_n;
                if (i_cmd.store_tmp) begin
                    r_tmp[i_cmd.addr_a] <= sum_s.v;
                end
                if (i_cmd.store_scr) begin
                    r_scr[i_cmd.dst] <= sum_s.v;
                end
            end
            m4au_pkg::DP_DETP:    r_det <= det_n;
            m4au_pkg::DP_DET_FIN: r_res <= det_s.v;
            m4au_pkg::DP_DIV_INIT: begin
                r_num  <= {a_mag, 16'd0};
                r_rem  <= '0;
                r_q    <= '0;
                r_dneg <= acc_rd[31] ^ r_val[31];
                r_dmag <= m4au_pkg::mag(r_val);
            end
            m4au_pkg::DP_DIV_STEP: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_dmag}) : div_t[31:0];
                r_q   <= {r_q[46:0], div_ge};
                r_num <= {r_num[46:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;

endmodule

>>> rtl/matrix4_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_arithmetic_unit
// Signed Q16.16 4x4 matrix unit with an accumulator and an operand matrix.
// ----------------------------------------------------------------------------
// Drive start with the action fields while busy is low; the beat is taken at
// that edge and busy rises until the single result beat has been produced.
// The result appears on o_result_value and o_status, marked by o_strobe for
// exactly one cycle, and cannot be held off, so capture it when it comes.
// Element writes, reads and unknown actions go straight from dispatch to the
// strobe; add, subtract and identity walk the 16 elements one per cycle;
// transpose goes through a staging copy. Matrix multiply, scale and the
// determinant all share one 32x32 multiplier with load, multiply and
// accumulate steps per product, except that scale writes each product
// straight back. Divide runs a bit-serial divider that forms 48 quotient
// bits per element; a zero divisor returns status 2 at once and leaves the
// accumulator untouched. Saturation anywhere gives status 1.
// ----------------------------------------------------------------------------
module matrix4_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_action,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);

    // Commands flow from the sequencer to the datapath; the only status
    // returned is whether the latched scalar is zero.
    m4au_pkg::t_dp_cmd    cmd;
    m4au_pkg::t_dp_status dp_status;

    m4au_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    m4au_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .o_status_dp    (dp_status),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

>>> rtl/m4au_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4au_checker
// Port-level checks of the matrix unit's beat sequencing.
// ----------------------------------------------------------------------------
module m4au_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic signed [31:0] o_result_value,
    input logic [1:0]         o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy did not rise after a beat");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result shown while still busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe repeated");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == m4au_pkg::ST_DIVZ |-> o_result_value == '0)
        else $error("divide by zero returned a value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_status <= m4au_pkg::ST_DIVZ) else $error("undefined status code");

endmodule

bind matrix4_arithmetic_unit m4au_checker u_m4au_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_result_value (o_result_value),
    .o_status       (o_status)
);
